// ===== sv/fsba_pkg.sv =====
// Package for the fit strategy block allocator.
// Holds strategy and status codes and shared constants; no dependencies.
package fsba_pkg;
    localparam int ARENA_BYTES_DEF = 65536;
    localparam int MAX_BLOCKS_DEF = 64;
    localparam int HEADER_BYTES_DEF = 24;
    localparam int LIST_HEADER_BYTES_DEF = 16;
    localparam int VAL_W = 21;

    localparam logic [2:0] STRAT_GROW = 3'd0;
    localparam logic [2:0] STRAT_FIRST = 3'd1;
    localparam logic [2:0] STRAT_BEST = 3'd2;
    localparam logic [2:0] STRAT_WORST = 3'd3;
    localparam logic [2:0] STRAT_NEXT = 3'd4;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    typedef struct packed {
        logic start;
        logic step;
        logic commit_alloc;
        logic commit_new;
        logic commit_rel;
    } t_cmd;

    typedef struct packed {
        logic alloc;
        logic done;
    } t_stat;
endpackage

// ===== sv/fsba_if.sv =====
// Valid/ready channel interfaces for the allocator.
// Depends on nothing.
interface fsba_in_if;
    logic valid;
    logic ready;
    logic cmd;
    logic [15:0] req_size;
    logic [15:0] block_addr;
    modport source (output valid, cmd, req_size, block_addr, input ready);
    modport sink (input valid, cmd, req_size, block_addr, output ready);
endinterface

interface fsba_out_if;
    logic valid;
    logic ready;
    logic [1:0] status;
    logic [15:0] addr;
    modport source (output valid, status, addr, input ready);
    modport sink (input valid, status, addr, output ready);
endinterface

// ===== sv/fsba_ctrl.sv =====
// Controller state machine of the allocator.
// Depends on fsba_pkg.
module fsba_ctrl (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  fsba_pkg::t_stat i_stat,
    output fsba_pkg::t_cmd o_cmd
);
    import fsba_pkg::*;
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;
    localparam logic [1:0] S_LINK = 2'd3;
    logic [1:0] r_state, n_state;
    logic r_out_valid, n_out_valid;

    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.start = 1'b1;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (i_stat.done) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit_alloc = i_stat.alloc;
                    o_cmd.commit_rel = !i_stat.alloc;
                    n_out_valid = 1'b1;
                    n_state = i_stat.alloc ? S_LINK : S_IDLE;
                end
            end
            S_LINK: begin
                o_cmd.commit_new = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTHESIS
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> r_out_valid) else $error("result dropped");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !o_in_ready) else $error("accept while busy");
    a_start_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> r_state == S_WALK) else $error("start lost");
`endif
endmodule

// ===== sv/fsba_dp.sv =====
// Datapath of the allocator: entry memory, chain walker and result register.
// Depends on fsba_pkg.
module fsba_dp #(
    parameter int ARENA_BYTES = 65536,
    parameter int MAX_BLOCKS = 64,
    parameter int HEADER_BYTES = 24,
    parameter int LIST_HEADER_BYTES = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  fsba_pkg::t_cmd i_cmd,
    output fsba_pkg::t_stat o_stat,
    input  logic [2:0] i_strategy,
    input  logic i_cmd_bit,
    input  logic [15:0] i_req_size,
    input  logic [15:0] i_block_addr,
    output logic [1:0] o_status,
    output logic [15:0] o_addr
);
    import fsba_pkg::*;
    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int LW = IW + 1;
    localparam logic [LW-1:0] LINK_NULL = LW'(MAX_BLOCKS);
    localparam logic [VAL_W-1:0] HDR = VAL_W'(HEADER_BYTES);

    typedef struct packed {
        logic [VAL_W-1:0] off;
        logic [VAL_W-1:0] size;
        logic [VAL_W-1:0] gap;
        logic [LW-1:0] link;
    } t_entry;

    t_entry r_mem [MAX_BLOCKS];
    t_entry r_rdata;
    logic [IW-1:0] rd_addr;
    logic wr_en;
    logic [IW-1:0] wr_addr;
    t_entry wr_data;

    logic [MAX_BLOCKS-1:0] r_used;
    logic [IW-1:0] r_last;

    logic r_alloc;
    logic [2:0] r_strat;
    logic [VAL_W-1:0] r_need;
    logic [15:0] r_req, r_baddr;
    logic [LW-1:0] r_cur, r_prev, r_pick;
    t_entry r_prev_ent, r_pick_ent, r_new_ent;
    logic [VAL_W-1:0] r_best;
    logic [LW:0] r_steps;
    logic r_done, r_found, r_ok;
    logic [LW-1:0] r_free;
    logic r_free_ok;
    logic [1:0] r_status;
    logic [15:0] r_addr;

    logic [IW-1:0] pick_i, prev_i, free_i;
    logic fits, hit, walk_end, grow_mode;
    logic [LW-1:0] lowfree;
    logic [VAL_W-1:0] new_off;

    assign pick_i = r_pick[IW-1:0];
    assign prev_i = r_prev[IW-1:0];
    assign free_i = r_free[IW-1:0];
    assign fits = r_rdata.gap != '0 && r_need <= r_rdata.gap;
    assign hit = r_cur != '0 && r_rdata.off + HDR == VAL_W'(r_baddr);
    assign walk_end = r_cur == LINK_NULL || r_steps == (LW+1)'(MAX_BLOCKS);
    assign grow_mode = r_strat == STRAT_GROW || r_strat == STRAT_NEXT;
    assign new_off = r_pick_ent.off + HDR + r_pick_ent.size;

    // Lowest unused slot, found by priority over the used bits.
    always_comb begin
        lowfree = LINK_NULL;
        for (int k = MAX_BLOCKS - 1; k >= 0; k--) begin
            if (!r_used[k]) lowfree = LW'(k);
        end
    end

    always_comb begin
        rd_addr = (r_rdata.link == LINK_NULL) ? '0 : r_rdata.link[IW-1:0];
        if (i_cmd.start) begin
            if (!i_cmd_bit && (i_strategy == STRAT_GROW || i_strategy == STRAT_NEXT)) begin
                rd_addr = r_last;
            end else begin
                rd_addr = '0;
            end
        end
    end

    always_comb begin
        wr_en = 1'b0;
        wr_addr = '0;
        wr_data = r_pick_ent;
        if (!i_rst_n) begin
            wr_en = 1'b1;
            wr_data.off = VAL_W'(LIST_HEADER_BYTES);
            wr_data.size = '0;
            wr_data.gap = VAL_W'(ARENA_BYTES - LIST_HEADER_BYTES - HEADER_BYTES);
            wr_data.link = LINK_NULL;
        end else if (i_cmd.commit_alloc) begin
            wr_en = r_found && r_free_ok;
            wr_addr = pick_i;
            wr_data.gap = '0;
            wr_data.link = r_free;
        end else if (i_cmd.commit_new) begin
            wr_en = r_ok;
            wr_addr = free_i;
            wr_data = r_new_ent;
        end else if (i_cmd.commit_rel) begin
            wr_en = r_found;
            wr_addr = prev_i;
            wr_data = r_prev_ent;
            wr_data.link = r_pick_ent.link;
            wr_data.gap = r_prev_ent.gap + HDR + r_pick_ent.size + r_pick_ent.gap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[rd_addr];
    end

    assign o_stat.alloc = r_alloc;
    assign o_stat.done = r_done;
    assign o_status = r_status;
    assign o_addr = r_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= MAX_BLOCKS'(1);
            r_last <= '0;
            r_done <= 1'b0;
            r_found <= 1'b0;
            r_ok <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_alloc <= !i_cmd_bit;
                r_strat <= i_strategy;
                r_req <= i_req_size;
                r_baddr <= i_block_addr;
                r_need <= VAL_W'(i_req_size) + HDR;
                r_cur <= '0;
                r_prev <= '0;
                r_pick <= LINK_NULL;
                r_best <= '0;
                r_steps <= '0;
                r_found <= 1'b0;
                r_done <= 1'b0;
                r_free <= lowfree;
                r_free_ok <= lowfree != LINK_NULL;
                if (!i_cmd_bit && (i_strategy == STRAT_GROW || i_strategy == STRAT_NEXT)) begin
                    r_cur <= LW'(r_last);
                end else if (!i_cmd_bit && i_strategy > STRAT_NEXT) begin
                    r_done <= 1'b1;
                end
            end else if (i_cmd.step) begin
                r_steps <= r_steps + 1'b1;
                if (walk_end) begin
                    r_done <= 1'b1;
                end else if (r_alloc && grow_mode) begin
                    r_done <= 1'b1;
                    r_found <= r_rdata.gap >= r_need;
                    r_pick <= r_cur;
                    r_pick_ent <= r_rdata;
                end else if (r_alloc) begin
                    if (fits) begin
                        if (r_strat == STRAT_FIRST) begin
                            r_done <= 1'b1;
                            r_found <= 1'b1;
                            r_pick <= r_cur;
                            r_pick_ent <= r_rdata;
                        end else if (!r_found || (r_strat == STRAT_BEST && r_rdata.gap <= r_best)
                                || (r_strat == STRAT_WORST && r_rdata.gap >= r_best)) begin
                            r_found <= 1'b1;
                            r_pick <= r_cur;
                            r_pick_ent <= r_rdata;
                            r_best <= r_rdata.gap;
                        end
                    end
                    r_cur <= r_rdata.link;
                end else if (hit) begin
                    r_done <= 1'b1;
                    r_found <= 1'b1;
                    r_pick <= r_cur;
                    r_pick_ent <= r_rdata;
                end else begin
                    r_prev <= r_cur;
                    r_prev_ent <= r_rdata;
                    r_cur <= r_rdata.link;
                end
            end
            if (i_cmd.commit_alloc) begin
                r_addr <= '0;
                r_ok <= r_found && r_free_ok;
                r_new_ent.off <= new_off;
                r_new_ent.size <= VAL_W'(r_req);
                r_new_ent.gap <= r_pick_ent.gap - r_need;
                r_new_ent.link <= r_pick_ent.link;
                if (!r_found) begin
                    r_status <= ST_NOFIT;
                end else if (!r_free_ok) begin
                    r_status <= ST_FULL;
                end else begin
                    r_status <= ST_OK;
                    r_addr <= 16'(new_off + HDR);
                    r_used[free_i] <= 1'b1;
                    if (grow_mode || r_pick_ent.link == LINK_NULL) begin
                        r_last <= free_i;
                    end
                end
            end
            if (i_cmd.commit_rel) begin
                r_addr <= '0;
                if (r_found) begin
                    r_status <= ST_OK;
                    r_used[pick_i] <= 1'b0;
                    if (r_last == pick_i) r_last <= prev_i;
                end else begin
                    r_status <= ST_UNKNOWN;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_head_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used[0]) else $error("head entry freed");
    a_last_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used[r_last]) else $error("last entry not in use");
    a_ok_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit_rel && r_found |=> r_status == ST_OK) else $error("release status");
    a_last_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit_alloc && r_found && r_free_ok |=> r_used[$past(free_i)])
        else $error("new entry not marked");
`endif
endmodule

// ===== sv/fit_strategy_block_allocator.sv =====
// Top level of the fit strategy block allocator: strategy register and glue.
// Depends on fsba_pkg, fsba_if, fsba_ctrl and fsba_dp.
// Before the result of a transaction is valid, the chain walk reads entries one a cycle from
// the entry memory: none for an allocate with an undefined strategy code, only the last
// entry for next fit and always grow, and up to the whole chain for first, best and worst
// fit and for a release. An allocate then writes the new entry in the S_LINK state, and a
// result that is not taken holds off the next transaction.
module fit_strategy_block_allocator #(
    parameter int ARENA_BYTES = fsba_pkg::ARENA_BYTES_DEF,
    parameter int MAX_BLOCKS = fsba_pkg::MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = fsba_pkg::HEADER_BYTES_DEF,
    parameter int LIST_HEADER_BYTES = fsba_pkg::LIST_HEADER_BYTES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic [2:0] i_cfg_data,
    fsba_in_if.sink i_in,
    fsba_out_if.source o_out
);
    import fsba_pkg::*;
    logic [2:0] r_strategy;
    t_cmd cmd;
    t_stat stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strategy <= STRAT_FIRST;
        end else if (i_cfg_we) begin
            r_strategy <= i_cfg_data;
        end
    end

    fsba_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in.valid), .o_in_ready(i_in.ready),
        .o_out_valid(o_out.valid), .i_out_ready(o_out.ready),
        .i_stat(stat), .o_cmd(cmd)
    );

    fsba_dp #(
        .ARENA_BYTES(ARENA_BYTES), .MAX_BLOCKS(MAX_BLOCKS),
        .HEADER_BYTES(HEADER_BYTES), .LIST_HEADER_BYTES(LIST_HEADER_BYTES)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat),
        .i_strategy(r_strategy), .i_cmd_bit(i_in.cmd),
        .i_req_size(i_in.req_size), .i_block_addr(i_in.block_addr),
        .o_status(o_out.status), .o_addr(o_out.addr)
    );
endmodule
